// File: rtl/lcdbs_pkg.sv
`timescale 1ns / 1ps

package lcdbs_pkg;

    localparam int PC_W  = 3;
    localparam int IDX_W = 3;
    localparam int CFG_W = 2;

    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_CMD    = 2'd1,
        ACT_CHAR   = 2'd2,
        ACT_CURSOR = 2'd3
    } action_t;

    localparam logic [CFG_W-1:0] CFG_BUS_MODE  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_PULSE_MS  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SETTLE_MS = 2'd2;
    localparam logic [CFG_W-1:0] CFG_POWER_MS  = 2'd3;

    localparam logic [7:0] RST_PULSE_MS  = 8'd1;
    localparam logic [7:0] RST_SETTLE_MS = 8'd5;
    localparam logic [7:0] RST_POWER_MS  = 8'd100;

    localparam logic [7:0] CMD_FUNC_8     = 8'h38;
    localparam logic [7:0] CMD_WAKE_A     = 8'h33;
    localparam logic [7:0] CMD_WAKE_B     = 8'h32;
    localparam logic [7:0] CMD_FUNC_4     = 8'h28;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY      = 8'h06;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] DDRAM_ROW0     = 8'h80;
    localparam logic [7:0] DDRAM_ROW1     = 8'hC0;

    localparam logic [IDX_W-1:0] INIT_LAST_8 = 3'd4;
    localparam logic [IDX_W-1:0] INIT_LAST_4 = 3'd6;

    localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] PC_POWER = 3'd1;
    localparam logic [PC_W-1:0] PC_B8_E1 = 3'd2;
    localparam logic [PC_W-1:0] PC_B8_E0 = 3'd3;
    localparam logic [PC_W-1:0] PC_HI_E1 = 3'd4;
    localparam logic [PC_W-1:0] PC_HI_E0 = 3'd5;
    localparam logic [PC_W-1:0] PC_LO_E1 = 3'd6;
    localparam logic [PC_W-1:0] PC_LO_E0 = 3'd7;

    typedef enum logic [1:0] {
        NIB_NONE = 2'd0,
        NIB_FULL = 2'd1,
        NIB_HI   = 2'd2,
        NIB_LO   = 2'd3
    } nib_t;

    typedef enum logic [1:0] {
        HOLD_ZERO   = 2'd0,
        HOLD_PULSE  = 2'd1,
        HOLD_SETTLE = 2'd2,
        HOLD_POWER  = 2'd3
    } hold_t;

    typedef enum logic [1:0] {
        JMP_SEQ  = 2'd0,
        JMP_BYTE = 2'd1,
        JMP_END  = 2'd2
    } jmp_t;

    typedef struct packed {
        logic  en;
        nib_t  nib;
        hold_t hold;
        jmp_t  jmp;
    } ucode_t;

    typedef struct packed {
        logic             fire;
        logic             en;
        nib_t             nib;
        hold_t            hold;
        logic             last;
        logic             src_init;
        logic [IDX_W-1:0] idx;
    } ctl_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:  w = '{en: 1'b0, nib: NIB_NONE, hold: HOLD_ZERO,   jmp: JMP_END};
            PC_POWER: w = '{en: 1'b0, nib: NIB_NONE, hold: HOLD_POWER,  jmp: JMP_BYTE};
            PC_B8_E1: w = '{en: 1'b1, nib: NIB_FULL, hold: HOLD_PULSE,  jmp: JMP_SEQ};
            PC_B8_E0: w = '{en: 1'b0, nib: NIB_FULL, hold: HOLD_SETTLE, jmp: JMP_END};
            PC_HI_E1: w = '{en: 1'b1, nib: NIB_HI,   hold: HOLD_PULSE,  jmp: JMP_SEQ};
            PC_HI_E0: w = '{en: 1'b0, nib: NIB_HI,   hold: HOLD_ZERO,   jmp: JMP_SEQ};
            PC_LO_E1: w = '{en: 1'b1, nib: NIB_LO,   hold: HOLD_PULSE,  jmp: JMP_SEQ};
            PC_LO_E0: w = '{en: 1'b0, nib: NIB_LO,   hold: HOLD_SETTLE, jmp: JMP_END};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] init_byte(input logic mode4, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = CMD_HOME;
        if (mode4) begin
            case (idx)
                3'd0:    b = CMD_WAKE_A;
                3'd1:    b = CMD_WAKE_B;
                3'd2:    b = CMD_FUNC_4;
                3'd3:    b = CMD_DISP_ON;
                3'd4:    b = CMD_CLEAR;
                3'd5:    b = CMD_ENTRY;
                default: b = CMD_HOME;
            endcase
        end else begin
            case (idx)
                3'd0:    b = CMD_FUNC_8;
                3'd1:    b = CMD_DISP_ON;
                3'd2:    b = CMD_CLEAR;
                3'd3:    b = CMD_ENTRY;
                default: b = CMD_HOME;
            endcase
        end
        return b;
    endfunction

endpackage

// File: rtl/lcdbs_useq.sv
`timescale 1ns / 1ps

module lcdbs_useq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                start_init,
    input  logic                bus_mode,
    input  logic                advance,
    output logic                idle,
    output lcdbs_pkg::ctl_t     ctl
);

    logic [lcdbs_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [lcdbs_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                        src_init_reg, src_init_next;
    lcdbs_pkg::ucode_t           uw;
    logic                        busy;
    logic                        more;
    logic [lcdbs_pkg::PC_W-1:0]  byte_pc;
    logic [lcdbs_pkg::IDX_W-1:0] idx_last;

    assign uw       = lcdbs_pkg::ucode_rom(pc_reg);
    assign busy     = (pc_reg != lcdbs_pkg::PC_IDLE);
    assign byte_pc  = bus_mode ? lcdbs_pkg::PC_HI_E1 : lcdbs_pkg::PC_B8_E1;
    assign idx_last = bus_mode ? lcdbs_pkg::INIT_LAST_4 : lcdbs_pkg::INIT_LAST_8;
    assign more     = src_init_reg && (idx_reg != idx_last);
    assign idle     = !busy;

    always_comb begin
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        src_init_next = src_init_reg;
        if (start) begin
            pc_next       = start_init ? lcdbs_pkg::PC_POWER : byte_pc;
            idx_next      = '0;
            src_init_next = start_init;
        end else if (busy && advance) begin
            unique case (uw.jmp)
                lcdbs_pkg::JMP_SEQ:  pc_next = pc_reg + 1'b1;
                lcdbs_pkg::JMP_BYTE: pc_next = byte_pc;
                lcdbs_pkg::JMP_END: begin
                    if (more) begin
                        pc_next  = byte_pc;
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        pc_next = lcdbs_pkg::PC_IDLE;
                    end
                end
                default: pc_next = lcdbs_pkg::PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= lcdbs_pkg::PC_IDLE;
            idx_reg      <= '0;
            src_init_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            idx_reg      <= idx_next;
            src_init_reg <= src_init_next;
        end
    end

    always_comb begin
        ctl.fire     = busy && advance;
        ctl.en       = uw.en;
        ctl.nib      = uw.nib;
        ctl.hold     = uw.hold;
        ctl.last     = (uw.jmp == lcdbs_pkg::JMP_END) && !more;
        ctl.src_init = src_init_reg;
        ctl.idx      = idx_reg;
    end

endmodule

// File: rtl/lcdbs_dpath.sv
`timescale 1ns / 1ps

module lcdbs_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lcdbs_pkg::CFG_W-1:0]  cfg_index,
    input  logic [7:0]                   cfg_wdata,
    input  logic                         start,
    input  logic [1:0]                   s_action,
    input  logic [7:0]                   s_value,
    input  logic                         s_row,
    input  logic [5:0]                   s_column,
    input  lcdbs_pkg::ctl_t              ctl,
    input  logic                         m_ready,
    output logic                         bus_mode,
    output logic                         advance,
    output logic                         m_valid,
    output logic                         m_reg_select,
    output logic                         m_enable,
    output logic [7:0]                   m_bus_data,
    output logic [7:0]                   m_hold_ms,
    output logic                         m_last
);

    logic       mode_reg;
    logic [7:0] pulse_reg, settle_reg, power_reg;
    logic [7:0] req_byte_reg, req_byte_next;
    logic       req_rs_reg;
    logic       valid_reg;
    logic       rs_reg, en_reg, last_reg;
    logic [7:0] data_reg, hold_reg;
    logic [7:0] byte_sel, data_next, hold_next;
    logic       rs_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            pulse_reg  <= lcdbs_pkg::RST_PULSE_MS;
            settle_reg <= lcdbs_pkg::RST_SETTLE_MS;
            power_reg  <= lcdbs_pkg::RST_POWER_MS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lcdbs_pkg::CFG_BUS_MODE:  mode_reg   <= cfg_wdata[0];
                lcdbs_pkg::CFG_PULSE_MS:  pulse_reg  <= cfg_wdata;
                lcdbs_pkg::CFG_SETTLE_MS: settle_reg <= cfg_wdata;
                lcdbs_pkg::CFG_POWER_MS:  power_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (s_action == lcdbs_pkg::ACT_CURSOR) begin
            req_byte_next = (s_row ? lcdbs_pkg::DDRAM_ROW1 : lcdbs_pkg::DDRAM_ROW0)
                          + {2'b00, s_column};
        end else begin
            req_byte_next = s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            req_byte_reg <= req_byte_next;
            req_rs_reg   <= (s_action == lcdbs_pkg::ACT_CHAR);
        end
    end

    assign byte_sel = ctl.src_init ? lcdbs_pkg::init_byte(mode_reg, ctl.idx) : req_byte_reg;
    assign rs_next  = ctl.src_init ? 1'b0 : req_rs_reg;

    always_comb begin
        unique case (ctl.nib)
            lcdbs_pkg::NIB_FULL: data_next = byte_sel;
            lcdbs_pkg::NIB_HI:   data_next = {4'h0, byte_sel[7:4]};
            lcdbs_pkg::NIB_LO:   data_next = {4'h0, byte_sel[3:0]};
            default:             data_next = 8'h00;
        endcase
        unique case (ctl.hold)
            lcdbs_pkg::HOLD_PULSE:  hold_next = pulse_reg;
            lcdbs_pkg::HOLD_SETTLE: hold_next = settle_reg;
            lcdbs_pkg::HOLD_POWER:  hold_next = power_reg;
            default:                hold_next = 8'h00;
        endcase
    end

    assign advance = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.fire) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fire) begin
            rs_reg   <= rs_next;
            en_reg   <= ctl.en;
            data_reg <= data_next;
            hold_reg <= hold_next;
            last_reg <= ctl.last;
        end
    end

    assign bus_mode     = mode_reg;
    assign m_valid      = valid_reg;
    assign m_reg_select = rs_reg;
    assign m_enable     = en_reg;
    assign m_bus_data   = data_reg;
    assign m_hold_ms    = hold_reg;
    assign m_last       = last_reg;

endmodule

// File: rtl/char_lcd_bus_sequencer.sv
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// s_        s_valid/s_ready    action, value, row, column
// m_        m_valid/m_ready    reg_select, enable, bus_data, hold_ms, last
// cfg_      cfg_we (no wait)   cfg_index, cfg_wdata
//
// One bus state leaves per cycle from a microcode step unless m_ready stalls the output;
// a byte is an enable-high then enable-low state, per nibble (high first) on a 4-bit bus;
// init leads with a power-up wait. The step counter and its program table set the order.
// aresetn is synchronous, active low; it restores register defaults and idles the counter.
// A stalled m_ready freezes the step counter; the next item is taken while the
// final state of the previous one still waits in the output register.

module char_lcd_bus_sequencer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lcdbs_pkg::CFG_W-1:0]  cfg_index,
    input  logic [7:0]                   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [7:0]                   s_value,
    input  logic                         s_row,
    input  logic [5:0]                   s_column,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_reg_select,
    output logic                         m_enable,
    output logic [7:0]                   m_bus_data,
    output logic [7:0]                   m_hold_ms,
    output logic                         m_last
);

    lcdbs_pkg::ctl_t ctl;
    logic            idle;
    logic            start;
    logic            bus_mode;
    logic            advance;

    assign s_ready = idle;
    assign start   = s_valid && idle;

    lcdbs_useq u_useq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_init (s_action == lcdbs_pkg::ACT_INIT),
        .bus_mode   (bus_mode),
        .advance    (advance),
        .idle       (idle),
        .ctl        (ctl)
    );

    lcdbs_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .s_action     (s_action),
        .s_value      (s_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .ctl          (ctl),
        .m_ready      (m_ready),
        .bus_mode     (bus_mode),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_bus_data   (m_bus_data),
        .m_hold_ms    (m_hold_ms),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer idle right after accepting an item");

    a_last_not_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_enable) |-> !m_last)
        else $error("final bus state has enable high");

    a_fire_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire |-> (!idle && advance))
        else $error("step fired without a free output slot");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lcdbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_BLOCK = 58;
    localparam int RANDOM_BLOCKS = 6;

    localparam logic [7:0] INIT_SEQ_8 [5] = '{CMD_FUNC_8, CMD_DISP_ON, CMD_CLEAR, CMD_ENTRY,
                                              CMD_HOME};
    localparam logic [7:0] INIT_SEQ_4 [7] = '{CMD_WAKE_A, CMD_WAKE_B, CMD_FUNC_4, CMD_DISP_ON,
                                              CMD_CLEAR, CMD_ENTRY, CMD_HOME};

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
        logic       row;
        logic [5:0] column;
    } lcd_req_t;

    typedef struct packed {
        logic       reg_select;
        logic       enable;
        logic [7:0] bus_data;
        logic [7:0] hold_ms;
        logic       last;
    } bus_state_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_W-1:0]     cfg_index = CFG_BUS_MODE;
    logic [7:0]           cfg_wdata = 8'd0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action = ACT_INIT;
    logic [7:0]           s_value = 8'd0;
    logic                 s_row = 1'b0;
    logic [5:0]           s_column = 6'd0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_reg_select;
    logic                 m_enable;
    logic [7:0]           m_bus_data;
    logic [7:0]           m_hold_ms;
    logic                 m_last;

    // register shadow
    logic                 mode4 = 1'b0;
    logic [7:0]           pulse_ms = RST_PULSE_MS;
    logic [7:0]           settle_ms = RST_SETTLE_MS;
    logic [7:0]           power_ms = RST_POWER_MS;

    lcd_req_t             pending_reqs[$];
    bus_state_t           states_due[$];
    lcd_req_t             cur_req;
    bus_state_t           got_state;
    bus_state_t           want_state;

    int                   tx_idle_pct = 23;
    int                   rx_idle_pct = 80;
    int                   issued_cnt = 0;
    int                   accepted_cnt = 0;
    int                   states_checked = 0;
    int                   mismatches = 0;
    int                   idle_cycles = 0;
    int                   settings_used = 1;
    int                   action_seen [4] = '{0, 0, 0, 0};

    char_lcd_bus_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .s_row       (s_row),
        .s_column    (s_column),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_select(m_reg_select),
        .m_enable    (m_enable),
        .m_bus_data  (m_bus_data),
        .m_hold_ms   (m_hold_ms),
        .m_last      (m_last)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic void push_state(input logic rs, input logic en, input logic [7:0] data,
                                       input logic [7:0] hold, input logic fin);
        bus_state_t st;
        st = '{reg_select: rs, enable: en, bus_data: data, hold_ms: hold, last: fin};
        states_due.push_back(st);
    endfunction

    function automatic void push_byte(input logic rs, input logic [7:0] b, input logic fin);
        if (mode4) begin
            push_state(rs, 1'b1, {4'h0, b[7:4]}, pulse_ms, 1'b0);
            push_state(rs, 1'b0, {4'h0, b[7:4]}, 8'd0, 1'b0);
            push_state(rs, 1'b1, {4'h0, b[3:0]}, pulse_ms, 1'b0);
            push_state(rs, 1'b0, {4'h0, b[3:0]}, settle_ms, fin);
        end else begin
            push_state(rs, 1'b1, b, pulse_ms, 1'b0);
            push_state(rs, 1'b0, b, settle_ms, fin);
        end
    endfunction

    function automatic void expand_request(input lcd_req_t r);
        logic [7:0] addr;
        addr = (r.row ? DDRAM_ROW1 : DDRAM_ROW0) + {2'b00, r.column};
        case (r.action)
            ACT_INIT: begin
                push_state(1'b0, 1'b0, 8'h00, power_ms, 1'b0);
                if (mode4) begin
                    for (int i = 0; i < 7; i++) push_byte(1'b0, INIT_SEQ_4[i], i == 6);
                end else begin
                    for (int i = 0; i < 5; i++) push_byte(1'b0, INIT_SEQ_8[i], i == 4);
                end
            end
            ACT_CMD:  push_byte(1'b0, r.value, 1'b1);
            ACT_CHAR: push_byte(1'b1, r.value, 1'b1);
            default:  push_byte(1'b0, addr, 1'b1);
        endcase
    endfunction

    function automatic lcd_req_t mk_req(input action_t a, input logic [7:0] v, input logic rw,
                                        input logic [5:0] col);
        lcd_req_t r;
        r = '{action: a, value: v, row: rw, column: col};
        return r;
    endfunction

    function automatic lcd_req_t random_req();
        int pick;
        action_t a;
        logic [5:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 8) a = ACT_INIT;
        else if (pick < 38) a = ACT_CMD;
        else if (pick < 70) a = ACT_CHAR;
        else a = ACT_CURSOR;
        // columns past the visible line now and then
        if ($urandom_range(0, 4) == 0) col = 6'($urandom_range(40, 63));
        else col = 6'($urandom_range(0, 39));
        return mk_req(a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || issued_cnt != accepted_cnt || states_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic program_regs(input logic m4, input logic [7:0] pulse, input logic [7:0] settle,
                                input logic [7:0] power);
        wait_idle();
        write_reg(CFG_BUS_MODE, {7'd0, m4});
        write_reg(CFG_PULSE_MS, pulse);
        write_reg(CFG_SETTLE_MS, settle);
        write_reg(CFG_POWER_MS, power);
        @(negedge aclk);
        cfg_we <= 1'b0;
        mode4 = m4;
        pulse_ms = pulse;
        settle_ms = settle;
        power_ms = power;
        settings_used++;
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && accepted_cnt != issued_cnt)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                issued_cnt++;
                s_valid <= 1'b1;
                s_action <= cur_req.action;
                s_value <= cur_req.value;
                s_row <= cur_req.row;
                s_column <= cur_req.column;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // receiver and scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_state = '{reg_select: m_reg_select, enable: m_enable, bus_data: m_bus_data,
                              hold_ms: m_hold_ms, last: m_last};
                if (states_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected bus state rs=%0d e=%0d d=%02h hold=%0d last=%0d",
                                 $realtime, m_reg_select, m_enable, m_bus_data, m_hold_ms, m_last);
                end else begin
                    want_state = states_due.pop_front();
                    states_checked++;
                    if (got_state != want_state) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp rs=%0d e=%0d d=%02h hold=%0d last=%0d, %s",
                                     $realtime, want_state.reg_select, want_state.enable,
                                     want_state.bus_data, want_state.hold_ms, want_state.last,
                                     $sformatf("got rs=%0d e=%0d d=%02h hold=%0d last=%0d",
                                               m_reg_select, m_enable, m_bus_data, m_hold_ms,
                                               m_last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expand_request(mk_req(action_t'(s_action), s_value, s_row, s_column));
                action_seen[s_action]++;
                accepted_cnt++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d bus states outstanding",
                         WATCHDOG_LIMIT, states_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings, 8-bit bus
        pending_reqs.push_back(mk_req(ACT_INIT, 8'h00, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CMD, 8'h00, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CMD, 8'hFF, 1'b1, 6'd63));
        pending_reqs.push_back(mk_req(ACT_CHAR, 8'h00, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CHAR, 8'hFF, 1'b1, 6'd63));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'h00, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'hFF, 1'b1, 6'd39));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'h00, 1'b0, 6'd40));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'h00, 1'b1, 6'd63));

        program_regs(1'b1, 8'd255, 8'd0, 8'd0);
        pending_reqs.push_back(mk_req(ACT_INIT, 8'hFF, 1'b1, 6'd63));
        pending_reqs.push_back(mk_req(ACT_CMD, 8'hA5, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CHAR, 8'h5A, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'h00, 1'b1, 6'd63));
        pending_reqs.push_back(mk_req(ACT_CURSOR, 8'h00, 1'b0, 6'd0));

        program_regs(1'b1, 8'd0, 8'd255, 8'd255);
        pending_reqs.push_back(mk_req(ACT_INIT, 8'h00, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_CHAR, 8'hFF, 1'b0, 6'd0));

        // bus width change without a fresh init
        program_regs(1'b0, 8'd0, 8'd255, 8'd255);
        pending_reqs.push_back(mk_req(ACT_CMD, 8'h3C, 1'b0, 6'd0));
        pending_reqs.push_back(mk_req(ACT_INIT, 8'h00, 1'b0, 6'd0));

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            wait_idle();
            if (blk < 2) begin
                tx_idle_pct = 23;
                rx_idle_pct = 80;
            end else if (blk < 4) begin
                tx_idle_pct = 80;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (blk)
                2:       program_regs(1'b1, 8'd0, 8'd0, 8'd0);
                4:       program_regs(1'b0, 8'd255, 8'd255, 8'd255);
                default: program_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
                if (i == ITEMS_PER_BLOCK / 2) wait_idle();
                pending_reqs.push_back(random_req());
            end
        end

        wait_idle();
        repeat (40) @(negedge aclk);
        $display("Ran %0d requests (%0d init, %0d command, %0d char, %0d cursor) over %0d %s",
                 accepted_cnt, action_seen[0], action_seen[1], action_seen[2], action_seen[3],
                 settings_used, "register settings in both bus widths");
        $display("Checked %0d bus states, %0d mismatches", states_checked, mismatches);
        if (mismatches == 0 && states_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
